/* sv/record_exchange_sort_macros.svh */
// Assertion helpers for the record sorter
`ifndef RECORD_EXCHANGE_SORT_MACROS_SVH
`define RECORD_EXCHANGE_SORT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define RXS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RXS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rxs_pkg.sv */
`default_nettype none

package rxs_pkg;

    localparam int ID_W    = 34;
    localparam int GRADE_W = 9;
    localparam int NAME_W  = 64;
    localparam int TAG_W   = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [GRADE_W-1:0] grade;
        logic [NAME_W-1:0]  name;
        logic [TAG_W-1:0]   tag;
    } t_rec;

    localparam logic [1:0] KEY_ID    = 2'd0;
    localparam logic [1:0] KEY_NAME  = 2'd1;
    localparam logic [1:0] KEY_GRADE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SORT_KEY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DESC     = 2'd1;

endpackage

`default_nettype wire

/* sv/record_exchange_sort.sv */
// record_exchange_sort: collects a set of records and returns them sorted.
// Input channel (i_valid / o_stall): one record word per cycle while loading.
// A word with i_last_record closes the set; words past RECORDS are dropped,
// but their last mark still closes the set.
// The set is then exchange sorted in place in a single record RAM with one
// read and one write port: position i is held in a register and compared
// against every later entry read back from the RAM, one compare per cycle.
// Output channel (o_valid / i_stall): N words, the final one with o_out_last.
// o_stall stays high from the last input word until the final sorted word
// is in the output register.
// A stalled output word holds; the emitter waits on it and nothing is lost.
// The user must set key/direction via the cfg port while the block is idle.
// Reset (synchronous, i_rst_n low) empties the set, drops any pending output
// word, and selects ascending by id number.
`default_nettype none
`include "record_exchange_sort_macros.svh"

module record_exchange_sort
    import rxs_pkg::*;
#(
    parameter int RECORDS    = 16,
    parameter int NAME_BYTES = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [ID_W-1:0]       i_student_id,
    input  wire logic [GRADE_W-1:0]    i_grade_hundredths,
    input  wire logic [NAME_W-1:0]     i_name_prefix,
    input  wire logic [TAG_W-1:0]      i_record_tag,
    input  wire logic                  i_last_record,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [ID_W-1:0]            o_out_student_id,
    output logic [GRADE_W-1:0]         o_out_grade_hundredths,
    output logic [NAME_W-1:0]          o_out_name_prefix,
    output logic [TAG_W-1:0]           o_out_record_tag,
    output logic                       o_out_last
);

    localparam int AW = $clog2(RECORDS);
    localparam int CW = $clog2(RECORDS + 1);

    typedef enum logic [6:0] {
        S_LOAD = 7'b0000001,
        S_LDI  = 7'b0000010,
        S_CUR  = 7'b0000100,
        S_CMP  = 7'b0001000,
        S_WBI  = 7'b0010000,
        S_ORD  = 7'b0100000,
        S_OEM  = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_n, n_n;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic [AW-1:0] r_k, n_k;
    t_rec          r_cur, n_cur;
    t_rec          r_out, n_out;
    logic          r_olast, n_olast;
    logic          r_ov, n_ov;
    logic [1:0]    r_sort_key;
    logic          r_desc;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_rec          mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    t_rec          mem_q;

    logic          swap;
    logic [CW-1:0] cnt_inc;
    t_rec          in_rec;
    logic          out_free;

    rxs_mem #(
        .DEPTH (RECORDS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    rxs_cmp #(
        .NAME_BYTES (NAME_BYTES)
    ) u_cmp (
        .i_lo         (r_cur),
        .i_hi         (mem_q),
        .i_sort_key   (r_sort_key),
        .i_descending (r_desc),
        .o_swap       (swap)
    );

    assign in_rec   = '{id: i_student_id, grade: i_grade_hundredths,
                        name: i_name_prefix, tag: i_record_tag};
    assign cnt_inc  = (r_cnt < CW'(RECORDS)) ? r_cnt + CW'(1) : r_cnt;
    assign out_free = !r_ov || !i_stall;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_n       = r_n;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_cur     = r_cur;
        n_out     = r_out;
        n_olast   = r_olast;
        n_ov      = r_ov && i_stall;
        mem_we    = 1'b0;
        mem_waddr = r_j;
        mem_wdata = r_cur;
        mem_re    = 1'b0;
        mem_raddr = r_j;
        unique case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    if (r_cnt < CW'(RECORDS)) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_cnt[AW-1:0];
                        mem_wdata = in_rec;
                    end
                    if (i_last_record) begin
                        n_n   = cnt_inc;
                        n_cnt = '0;
                        n_i   = '0;
                        n_k   = '0;
                        n_state = (cnt_inc >= CW'(2)) ? S_LDI : S_ORD;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
            end
            S_LDI: begin
                mem_re    = 1'b1;
                mem_raddr = r_i;
                n_j       = r_i + AW'(1);
                n_state   = S_CUR;
            end
            S_CUR: begin
                n_cur     = mem_q;
                mem_re    = 1'b1;
                mem_raddr = r_j;
                n_state   = S_CMP;
            end
            S_CMP: begin
                if (swap) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_j;
                    mem_wdata = r_cur;
                    n_cur     = mem_q;
                end
                if ((CW'(r_j) + CW'(1)) == r_n) begin
                    n_state = S_WBI;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_j + AW'(1);
                    n_j       = r_j + AW'(1);
                end
            end
            S_WBI: begin
                mem_we    = 1'b1;
                mem_waddr = r_i;
                mem_wdata = r_cur;
                n_i       = r_i + AW'(1);
                if ((CW'(r_i) + CW'(2)) == r_n) begin
                    n_k     = '0;
                    n_state = S_ORD;
                end else begin
                    n_state = S_LDI;
                end
            end
            S_ORD: begin
                mem_re    = 1'b1;
                mem_raddr = r_k;
                n_state   = S_OEM;
            end
            S_OEM: begin
                if (out_free) begin
                    n_out   = mem_q;
                    n_olast = (CW'(r_k) + CW'(1)) == r_n;
                    n_ov    = 1'b1;
                    if ((CW'(r_k) + CW'(1)) == r_n) begin
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_n     <= n_n;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_out   <= n_out;
        r_olast <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_key <= KEY_ID;
            r_desc     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SORT_KEY: r_sort_key <= i_cfg_data[1:0];
                REG_DESC:     r_desc     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_stall                = (r_state != S_LOAD);
    assign o_valid                = r_ov;
    assign o_out_student_id       = r_out.id;
    assign o_out_grade_hundredths = r_out.grade;
    assign o_out_name_prefix      = r_out.name;
    assign o_out_record_tag       = r_out.tag;
    assign o_out_last             = r_olast;

    `RXS_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= CW'(RECORDS), "load count past capacity")
    `RXS_ASSERT_NOW(a_scan_order, r_state == S_CMP, r_j > r_i && CW'(r_j) < r_n, "bad scan index")
    `RXS_ASSERT_NEXT(a_wbi_next, r_state == S_WBI, r_state == S_LDI || r_state == S_ORD, "bad pass end")
    `RXS_ASSERT_NOW(a_emit_hold, r_state == S_OEM && r_ov && i_stall, n_state == S_OEM, "emit overran output")

endmodule

`default_nettype wire

/* sv/rxs_mem.sv */
`default_nettype none

module rxs_mem
    import rxs_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_rec          i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output t_rec               o_rdata
);

    t_rec r_mem [DEPTH];
    t_rec r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

/* sv/rxs_cmp.sv */
`default_nettype none

module rxs_cmp
    import rxs_pkg::*;
#(
    parameter int NAME_BYTES = 8
) (
    input  wire t_rec       i_lo,
    input  wire t_rec       i_hi,
    input  wire logic [1:0] i_sort_key,
    input  wire logic       i_descending,
    output logic            o_swap
);

    localparam logic [NAME_W-1:0] NAME_MASK =
        ~((NAME_W'(1) << (NAME_W - 8 * NAME_BYTES)) - NAME_W'(1));

    logic [NAME_W-1:0] key_lo;
    logic [NAME_W-1:0] key_hi;

    always_comb begin
        unique case (i_sort_key)
            KEY_NAME: begin
                key_lo = i_lo.name & NAME_MASK;
                key_hi = i_hi.name & NAME_MASK;
            end
            KEY_GRADE: begin
                key_lo = NAME_W'(i_lo.grade);
                key_hi = NAME_W'(i_hi.grade);
            end
            default: begin
                key_lo = NAME_W'(i_lo.id);
                key_hi = NAME_W'(i_hi.id);
            end
        endcase
    end

    // equal keys never swap
    assign o_swap = i_descending ? (key_lo < key_hi) : (key_lo > key_hi);

endmodule

`default_nettype wire
